FILE: rtl/scrf_pkg.sv
// Shared types, codes and constants of the serial command/response framer.
package scrf_pkg;

	localparam int MAX_PAYLOAD_BYTES = 7;
	localparam int MAX_REPLY_BYTES   = 10;
	localparam int DATA_MAX_BYTES    = 6;
	localparam int DATA_LIMIT        = 3 + DATA_MAX_BYTES;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int PLEN_W = $clog2(MAX_PAYLOAD_BYTES + 1);

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 16;

	localparam logic [7:0] HDR_CMD   = 8'hFA;
	localparam logic [7:0] HDR_REPLY = 8'hFB;
	localparam logic [7:0] BYTE_MAX  = 8'hFF;

	localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS  = 1'd1;

	localparam logic [1:0] REQ_SEND = 2'd0;
	localparam logic [1:0] REQ_LINE = 2'd1;
	localparam logic [1:0] REQ_TICK = 2'd2;

	localparam logic KIND_TX      = 1'b0;
	localparam logic KIND_OUTCOME = 1'b1;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_MISMATCH = 2'd1;
	localparam logic [1:0] STATUS_TIMEOUT  = 2'd2;

	// One unit of work handed from front to back: a frame to send or an outcome.
	typedef struct packed {
		logic              is_frame;
		logic              no_reply;
		logic [7:0]        addr;
		logic [7:0]        cmd;
		logic [55:0]       payload;
		logic [PLEN_W-1:0] plen;
		logic [1:0]        status;
		logic [47:0]       data;
		logic [2:0]        dlen;
		logic [7:0]        fail;
	} job_t;

endpackage

FILE: rtl/serial_command_response_framer.sv
// Top level of the serial command/response framer.
// Requests come in three kinds: send command, received line byte and time tick. The
// front part takes one request per clock while its job queue (four entries) has room,
// tracks the reply hunt/collect state, the tick count and the consecutive-failure
// count, and queues at most one job per request: a frame to send or a transaction
// outcome. The back part drains the queue through a registered output, one result
// per clock while out_stall is low. A send command yields 4 + payload_len transmit
// bytes (0xFA, address, command, payload most significant first, 8-bit sum), plus an
// ok outcome when no reply is awaited; a completed reply or a timeout is one outcome.
// Line bytes and ticks that cause no result still pass through the front; in_stall
// rises only when the queue is full. Configuration writes take effect on the next
// clock and are meant for idle periods only.
module serial_command_response_framer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [scrf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [scrf_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       req_type,
	input  logic [7:0]                       cmd_code,
	input  logic [55:0]                      payload,
	input  logic [2:0]                       payload_len,
	input  logic [3:0]                       reply_len,
	input  logic [7:0]                       line_byte,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             out_kind,
	output logic [7:0]                       tx_byte,
	output logic                             last,
	output logic [1:0]                       status,
	output logic [47:0]                      reply_data,
	output logic [2:0]                       reply_data_len,
	output logic [7:0]                       fail_count
);
	import scrf_pkg::*;

	// Jobs travel from front to back through the queue.
	logic q_full;
	logic q_empty;
	logic push;
	logic pop;
	job_t push_job;
	job_t head;

	// Classify each request and advance the reply tracking state.
	scrf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.cmd_code    (cmd_code),
		.payload     (payload),
		.payload_len (payload_len),
		.reply_len   (reply_len),
		.line_byte   (line_byte),
		.q_full      (q_full),
		.push        (push),
		.push_job    (push_job)
	);

	// Hold jobs so the front keeps accepting while frames are still going out.
	scrf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	// Expand jobs into the result stream, one item per cycle while out_stall is low.
	scrf_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.q_empty        (q_empty),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_kind       (out_kind),
		.tx_byte        (tx_byte),
		.last           (last),
		.status         (status),
		.reply_data     (reply_data),
		.reply_data_len (reply_data_len),
		.fail_count     (fail_count)
	);

endmodule

FILE: rtl/scrf_front.sv
// Front part: accept requests, track the reply state and queue jobs for the back part.
module scrf_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [scrf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [scrf_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       req_type,
	input  logic [7:0]                       cmd_code,
	input  logic [55:0]                      payload,
	input  logic [2:0]                       payload_len,
	input  logic [3:0]                       reply_len,
	input  logic [7:0]                       line_byte,
	input  logic                             q_full,
	output logic                             push,
	output scrf_pkg::job_t                   push_job
);
	import scrf_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'b001,
		PH_HUNT    = 3'b010,
		PH_COLLECT = 3'b100
	} phase_t;

	logic [7:0]  device_addr_q;
	logic [15:0] timeout_q;

	phase_t      phase_q, phase_n;
	logic [3:0]  byte_index_q, byte_index_n;
	logic [3:0]  exp_len_q, exp_len_n;
	logic [7:0]  exp_cmd_q, exp_cmd_n;
	logic [7:0]  addr_seen_q, addr_seen_n;
	logic [7:0]  cmd_seen_q, cmd_seen_n;
	logic [47:0] data_q, data_n;
	logic [15:0] tick_q, tick_n;
	logic [7:0]  fail_q, fail_n;

	logic        accept;
	logic        has_job;
	job_t        job;
	logic [3:0]  bi_inc;
	logic [PLEN_W-1:0] plen_c;
	logic [3:0]  rlen_c;

	function automatic job_t finish_job(input logic [3:0] elen, input logic [7:0] a_seen,
			input logic [7:0] dev, input logic [7:0] c_seen, input logic [7:0] c_exp,
			input logic [47:0] dat);
		job_t       j;
		logic [3:0] d;
		j = '0;
		j.status = STATUS_OK;
		if (elen >= 4'd2 && a_seen != dev)
			j.status = STATUS_MISMATCH;
		if (elen >= 4'd3 && c_seen != c_exp)
			j.status = STATUS_MISMATCH;
		d = (elen > 4'd4) ? elen - 4'd4 : 4'd0;
		if (d > 4'(DATA_MAX_BYTES))
			d = 4'(DATA_MAX_BYTES);
		j.dlen = d[2:0];
		j.data = dat;
		j.fail = 8'd0;
		return j;
	endfunction

	assign accept   = in_valid & ~q_full;
	assign in_stall = q_full;
	assign push     = accept & has_job;
	assign push_job = job;

	assign bi_inc = byte_index_q + 4'd1;
	assign plen_c = ({1'b0, payload_len} > 4'(MAX_PAYLOAD_BYTES)) ?
		PLEN_W'(MAX_PAYLOAD_BYTES) : PLEN_W'(payload_len);
	assign rlen_c = ({1'b0, reply_len} > 5'(MAX_REPLY_BYTES)) ?
		4'(MAX_REPLY_BYTES) : reply_len;

	always_comb begin
		phase_n      = phase_q;
		byte_index_n = byte_index_q;
		exp_len_n    = exp_len_q;
		exp_cmd_n    = exp_cmd_q;
		addr_seen_n  = addr_seen_q;
		cmd_seen_n   = cmd_seen_q;
		data_n       = data_q;
		tick_n       = tick_q;
		fail_n       = fail_q;
		has_job      = 1'b0;
		job          = '0;
		unique case (req_type)
			REQ_SEND: begin
				has_job      = 1'b1;
				job.is_frame = 1'b1;
				job.no_reply = (rlen_c == 4'd0);
				job.addr     = device_addr_q;
				job.cmd      = cmd_code;
				job.payload  = payload;
				job.plen     = plen_c;
				exp_cmd_n    = cmd_code;
				exp_len_n    = rlen_c;
				byte_index_n = 4'd0;
				addr_seen_n  = 8'd0;
				cmd_seen_n   = 8'd0;
				data_n       = 48'd0;
				tick_n       = 16'd0;
				if (rlen_c == 4'd0) begin
					phase_n = PH_IDLE;
					fail_n  = 8'd0;
				end else begin
					phase_n = PH_HUNT;
				end
			end
			REQ_LINE: begin
				unique case (phase_q)
					PH_HUNT: begin
						if (line_byte == HDR_REPLY) begin
							byte_index_n = 4'd1;
							phase_n      = PH_COLLECT;
							if (exp_len_q <= 4'd1) begin
								has_job = 1'b1;
								job     = finish_job(exp_len_q, addr_seen_q, device_addr_q,
									cmd_seen_q, exp_cmd_q, data_q);
								fail_n  = 8'd0;
								phase_n = PH_IDLE;
							end
						end
					end
					PH_COLLECT: begin
						if (byte_index_q == 4'd1)
							addr_seen_n = line_byte;
						else if (byte_index_q == 4'd2)
							cmd_seen_n = line_byte;
						else if (bi_inc < exp_len_q && byte_index_q < 4'(DATA_LIMIT))
							data_n = {data_q[39:0], line_byte};
						byte_index_n = bi_inc;
						if (bi_inc >= exp_len_q) begin
							has_job = 1'b1;
							job     = finish_job(exp_len_q, addr_seen_n, device_addr_q,
								cmd_seen_n, exp_cmd_q, data_n);
							fail_n  = 8'd0;
							phase_n = PH_IDLE;
						end
					end
					default: ;
				endcase
			end
			REQ_TICK: begin
				if (phase_q != PH_IDLE) begin
					tick_n = (tick_q != 16'hFFFF) ? tick_q + 16'd1 : tick_q;
					if (tick_n >= timeout_q) begin
						fail_n     = (fail_q != BYTE_MAX) ? fail_q + 8'd1 : fail_q;
						phase_n    = PH_IDLE;
						has_job    = 1'b1;
						job.status = STATUS_TIMEOUT;
						job.fail   = fail_n;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_addr_q <= 8'd1;
			timeout_q     <= 16'd100;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_DEVICE_ADDRESS: device_addr_q <= cfg_data[7:0];
				REG_TIMEOUT_TICKS:  timeout_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			byte_index_q <= 4'd0;
			exp_len_q    <= 4'd0;
			exp_cmd_q    <= 8'd0;
			addr_seen_q  <= 8'd0;
			cmd_seen_q   <= 8'd0;
			data_q       <= 48'd0;
			tick_q       <= 16'd0;
			fail_q       <= 8'd0;
		end else if (accept) begin
			phase_q      <= phase_n;
			byte_index_q <= byte_index_n;
			exp_len_q    <= exp_len_n;
			exp_cmd_q    <= exp_cmd_n;
			addr_seen_q  <= addr_seen_n;
			cmd_seen_q   <= cmd_seen_n;
			data_q       <= data_n;
			tick_q       <= tick_n;
			fail_q       <= fail_n;
		end
	end

	a_collect_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_COLLECT) |-> (byte_index_q < exp_len_q && byte_index_q != 4'd0))
		else $error("collect index out of range");

endmodule

FILE: rtl/scrf_queue.sv
// Short job queue between the front and back parts.
module scrf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  scrf_pkg::job_t push_job,
	input  logic           pop,
	output scrf_pkg::job_t head,
	output logic           full,
	output logic           empty
);
	import scrf_pkg::*;

	job_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("pop from empty queue");

endmodule

FILE: rtl/scrf_back.sv
// Back part: expand queued jobs into transmit bytes and outcomes through an output register.
module scrf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  scrf_pkg::job_t head,
	input  logic           q_empty,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic           out_kind,
	output logic [7:0]     tx_byte,
	output logic           last,
	output logic [1:0]     status,
	output logic [47:0]    reply_data,
	output logic [2:0]     reply_data_len,
	output logic [7:0]     fail_count
);
	import scrf_pkg::*;

	typedef enum logic [5:0] {
		B_IDLE = 6'b000001,
		B_ADDR = 6'b000010,
		B_CMD  = 6'b000100,
		B_PAY  = 6'b001000,
		B_SUM  = 6'b010000,
		B_OUT  = 6'b100000
	} bstate_t;

	bstate_t           state_q, state_n;
	job_t              job_q;
	logic              load;
	logic [PLEN_W-1:0] rem_q, rem_n;
	logic [7:0]        sum_q, sum_n;
	logic [2:0]        byte_sel;
	logic [7:0]        pay_byte;
	logic              advance;
	logic              emit;

	logic        valid_q;
	logic        kind_q, kind_n;
	logic [7:0]  tx_q, tx_n;
	logic        last_q, last_n;
	logic [1:0]  status_q, status_n;
	logic [47:0] data_q, data_n;
	logic [2:0]  dlen_q, dlen_n;
	logic [7:0]  fail_q, fail_n;

	assign advance  = ~valid_q | ~out_stall;
	assign byte_sel = 3'(rem_q - 1'b1);
	assign pay_byte = job_q.payload[{byte_sel, 3'b000} +: 8];

	always_comb begin
		state_n  = state_q;
		rem_n    = rem_q;
		sum_n    = sum_q;
		pop      = 1'b0;
		load     = 1'b0;
		emit     = 1'b0;
		kind_n   = KIND_TX;
		tx_n     = 8'd0;
		last_n   = 1'b0;
		status_n = STATUS_OK;
		data_n   = 48'd0;
		dlen_n   = 3'd0;
		fail_n   = 8'd0;
		if (advance) begin
			unique case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						pop  = 1'b1;
						emit = 1'b1;
						if (head.is_frame) begin
							load    = 1'b1;
							tx_n    = HDR_CMD;
							sum_n   = HDR_CMD;
							rem_n   = head.plen;
							state_n = B_ADDR;
						end else begin
							kind_n   = KIND_OUTCOME;
							last_n   = 1'b1;
							status_n = head.status;
							data_n   = head.data;
							dlen_n   = head.dlen;
							fail_n   = head.fail;
						end
					end
				end
				B_ADDR: begin
					emit    = 1'b1;
					tx_n    = job_q.addr;
					sum_n   = sum_q + job_q.addr;
					state_n = B_CMD;
				end
				B_CMD: begin
					emit    = 1'b1;
					tx_n    = job_q.cmd;
					sum_n   = sum_q + job_q.cmd;
					state_n = (rem_q != '0) ? B_PAY : B_SUM;
				end
				B_PAY: begin
					emit  = 1'b1;
					tx_n  = pay_byte;
					sum_n = sum_q + pay_byte;
					rem_n = rem_q - 1'b1;
					if (rem_q == PLEN_W'(1))
						state_n = B_SUM;
				end
				B_SUM: begin
					emit    = 1'b1;
					tx_n    = sum_q;
					last_n  = ~job_q.no_reply;
					state_n = job_q.no_reply ? B_OUT : B_IDLE;
				end
				B_OUT: begin
					emit    = 1'b1;
					kind_n  = KIND_OUTCOME;
					last_n  = 1'b1;
					state_n = B_IDLE;
				end
				default: state_n = B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (advance)
				valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		rem_q <= rem_n;
		sum_q <= sum_n;
		if (load)
			job_q <= head;
		if (advance && emit) begin
			kind_q   <= kind_n;
			tx_q     <= tx_n;
			last_q   <= last_n;
			status_q <= status_n;
			data_q   <= data_n;
			dlen_q   <= dlen_n;
			fail_q   <= fail_n;
		end
	end

	assign out_valid      = valid_q;
	assign out_kind       = kind_q;
	assign tx_byte        = tx_q;
	assign last           = last_q;
	assign status         = status_q;
	assign reply_data     = data_q;
	assign reply_data_len = dlen_q;
	assign fail_count     = fail_q;

	a_busy_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != B_IDLE) |-> valid_q)
		else $error("frame in progress without a pending output byte");
	a_outcome_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && kind_q == KIND_OUTCOME) |-> last_q)
		else $error("outcome not marked last");

endmodule
